@@ src/sacfl_pkg.sv @@
package sacfl_pkg;

   // Controller states, one-hot.
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the request address
      logic commit;  // perform the lookup, update the directory, load the result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free; // the result register can take a new result this cycle
   } status_type;

endpackage

@@ src/sacfl_req_if.sv @@
interface sacfl_req_if #(
   parameter int ADDR_BITS = 12
) ();
   logic                 valid;
   logic                 ready;
   logic [ADDR_BITS-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

@@ src/sacfl_rsp_if.sv @@
interface sacfl_rsp_if #(
   parameter int ADDR_BITS  = 12,
   parameter int WAY_BITS   = 2,
   parameter int COUNT_BITS = 16
) ();
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [WAY_BITS-1:0]   way;
   logic                  evicted;
   logic [ADDR_BITS-1:0]  block_base;
   logic [COUNT_BITS-1:0] hits_so_far;
   logic [COUNT_BITS-1:0] misses_so_far;

   modport source (output valid, output hit, output way, output evicted, output block_base,
                   output hits_so_far, output misses_so_far, input ready);
   modport sink   (input valid, input hit, input way, input evicted, input block_base,
                   input hits_so_far, input misses_so_far, output ready);
endinterface

@@ src/set_assoc_cache_fifo_lookup.sv @@
// Four-way set-associative cache directory with FIFO replacement. Each request transaction
// carries a word address; the block answers with one response transaction giving hit or
// miss, the way that hit or was filled, whether a valid block was replaced, the block base
// address and saturating hit and miss counts that include this access. A request is taken
// in the idle state and looked up and committed in the lookup state, so a new request is
// not accepted until the last one has committed; this is set by the accept/lookup loop,
// as each lookup reads directory state written by the one before. The response sits in an
// output register, so the next request is accepted while a response waits to be taken,
// and a stalled response holds the lookup only when the register is still occupied.
// Valid bits and replacement pointers clear in the reset cycle; no clearing pass follows.
module set_assoc_cache_fifo_lookup #(
   parameter int ADDR_BITS   = 12,
   parameter int WAYS        = 4,
   parameter int SET_BITS    = 1,
   parameter int OFFSET_BITS = 2,
   parameter int COUNT_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   sacfl_req_if.sink   req,
   sacfl_rsp_if.source rsp
);

   localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

   sacfl_pkg::cmd_type    cmd;
   sacfl_pkg::status_type status;
   logic                  ctrl_ready;

   assign req.ready = ctrl_ready;

   sacfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ctrl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sacfl_datapath #(
      .ADDR_BITS   (ADDR_BITS),
      .WAYS        (WAYS),
      .SET_BITS    (SET_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .WAY_BITS    (WAY_BITS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .address (req.address),
      .cmd     (cmd),
      .status  (status),
      .rsp     (rsp)
   );

endmodule

@@ src/sacfl_ctrl.sv @@
module sacfl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sacfl_pkg::status_type status,
   output sacfl_pkg::cmd_type    cmd
);

   sacfl_pkg::state_type state_ff;
   sacfl_pkg::state_type state_in;

   assign req_ready  = (state_ff == sacfl_pkg::ST_IDLE);
   assign cmd.load   = req_valid & req_ready;
   assign cmd.commit = (state_ff == sacfl_pkg::ST_LOOKUP) & status.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sacfl_pkg::ST_IDLE: begin
            if (cmd.load) begin
               state_in = sacfl_pkg::ST_LOOKUP;
            end
         end
         sacfl_pkg::ST_LOOKUP: begin
            if (status.out_free) begin
               state_in = sacfl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sacfl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sacfl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted request is always followed by a lookup cycle.
   a_load_to_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == sacfl_pkg::ST_LOOKUP))
      else $error("accepted request did not enter lookup");

   // A lookup that cannot commit keeps waiting and does not lose the request.
   a_lookup_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sacfl_pkg::ST_LOOKUP) && !status.out_free
         |=> (state_ff == sacfl_pkg::ST_LOOKUP))
      else $error("lookup dropped while result register was full");

endmodule

@@ src/sacfl_datapath.sv @@
module sacfl_datapath #(
   parameter int ADDR_BITS   = 12,
   parameter int WAYS        = 4,
   parameter int SET_BITS    = 1,
   parameter int OFFSET_BITS = 2,
   parameter int COUNT_BITS  = 16,
   parameter int WAY_BITS    = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [ADDR_BITS-1:0]   address,
   input  sacfl_pkg::cmd_type     cmd,
   output sacfl_pkg::status_type  status,
   sacfl_rsp_if.source            rsp
);

   localparam int TAG_BITS     = ADDR_BITS - SET_BITS - OFFSET_BITS;
   localparam int NUM_SETS     = 1 << SET_BITS;
   localparam int SET_IDX_BITS = (SET_BITS > 0) ? SET_BITS : 1;
   localparam logic [ADDR_BITS-1:0] OFFSET_MASK =
      ADDR_BITS'((64'd1 << OFFSET_BITS) - 64'd1);
   localparam logic [WAY_BITS:0] WAYS_LIMIT = (WAY_BITS+1)'(WAYS);

   // Directory state. Tags carry no reset; an invalid way never matches.
   logic [TAG_BITS-1:0]   tag_ff   [NUM_SETS][WAYS];
   logic                  valid_ff [NUM_SETS][WAYS];
   logic [WAY_BITS-1:0]   ptr_ff   [NUM_SETS];
   logic [COUNT_BITS-1:0] hit_cnt_ff;
   logic [COUNT_BITS-1:0] hit_cnt_in;
   logic [COUNT_BITS-1:0] miss_cnt_ff;
   logic [COUNT_BITS-1:0] miss_cnt_in;

   logic [ADDR_BITS-1:0]  addr_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  out_hit_ff;
   logic [WAY_BITS-1:0]   out_way_ff;
   logic                  out_evicted_ff;
   logic [ADDR_BITS-1:0]  out_base_ff;
   logic [COUNT_BITS-1:0] out_hits_ff;
   logic [COUNT_BITS-1:0] out_misses_ff;

   logic [SET_IDX_BITS-1:0] set_idx;
   logic [TAG_BITS-1:0]     tag;
   logic                    hit;
   logic [WAY_BITS-1:0]     hit_way;
   logic [WAY_BITS-1:0]     victim;
   logic                    evict;
   logic [WAY_BITS:0]       ptr_inc;
   logic [WAY_BITS-1:0]     ptr_next;
   logic [WAY_BITS-1:0]     res_way;

   generate
      if (SET_BITS > 0) begin : g_set
         assign set_idx = addr_ff[OFFSET_BITS +: SET_IDX_BITS];
      end else begin : g_noset
         assign set_idx = '0;
      end
   endgenerate

   assign tag = addr_ff[ADDR_BITS-1 -: TAG_BITS];

   // Parallel tag compare; the lowest matching way wins.
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (valid_ff[set_idx][w] && (tag_ff[set_idx][w] == tag)) begin
            hit     = 1'b1;
            hit_way = WAY_BITS'(w);
         end
      end
   end

   assign victim   = ptr_ff[set_idx];
   assign evict    = valid_ff[set_idx][victim];
   assign ptr_inc  = {1'b0, victim} + (WAY_BITS+1)'(1);
   assign ptr_next = (ptr_inc >= WAYS_LIMIT) ? '0 : ptr_inc[WAY_BITS-1:0];
   assign res_way  = hit ? hit_way : victim;

   assign hit_cnt_in  = (hit && !(&hit_cnt_ff)) ? hit_cnt_ff + COUNT_BITS'(1) : hit_cnt_ff;
   assign miss_cnt_in = (!hit && !(&miss_cnt_ff)) ?
                        miss_cnt_ff + COUNT_BITS'(1) : miss_cnt_ff;

   assign status.out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         for (int s = 0; s < NUM_SETS; s++) begin
            ptr_ff[s] <= '0;
            for (int w = 0; w < WAYS; w++) begin
               valid_ff[s][w] <= 1'b0;
            end
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            hit_cnt_ff  <= hit_cnt_in;
            miss_cnt_ff <= miss_cnt_in;
            if (!hit) begin
               valid_ff[set_idx][victim] <= 1'b1;
               ptr_ff[set_idx]           <= ptr_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff <= address;
      end
      if (cmd.commit) begin
         if (!hit) begin
            tag_ff[set_idx][victim] <= tag;
         end
         out_hit_ff     <= hit;
         out_way_ff     <= res_way;
         out_evicted_ff <= !hit && evict;
         out_base_ff    <= addr_ff & ~OFFSET_MASK;
         out_hits_ff    <= hit_cnt_in;
         out_misses_ff  <= miss_cnt_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.hit           = out_hit_ff;
   assign rsp.way           = out_way_ff;
   assign rsp.evicted       = out_evicted_ff;
   assign rsp.block_base    = out_base_ff;
   assign rsp.hits_so_far   = out_hits_ff;
   assign rsp.misses_so_far = out_misses_ff;

   // A committed lookup always leaves a result pending in the next cycle.
   a_commit_gives_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed lookup produced no result");

   // A hit never reports an eviction.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_hit_ff |-> !out_evicted_ff)
      else $error("hit reported with eviction");

   // After a miss the filled way is valid and holds the tag of the access.
   a_fill_matches: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !hit |=> hit)
      else $error("filled way does not match the access");

endmodule
